// ----- sv/fpcm_pkg.sv -----
// ----------------------------------------------------------------------------
// Fractal palette color mapper package
// Shared constants, types and a helper function of the palette color mapper.
// ----------------------------------------------------------------------------
package fpcm_pkg;

  // Fixed-point layout of the position and of the escape magnitude.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned MAG_FRAC  = 16;
  localparam int unsigned ITER_BITS = 16;

  // Palette storage.
  localparam int unsigned PAL_DEPTH = 16;
  localparam int unsigned PAL_AW    = 4;

  // Datapath widths and pipeline lengths.
  localparam int unsigned J_W       = ITER_BITS + 1 + FRAC_BITS;  // position j
  localparam int unsigned NUM_W     = J_W + PAL_AW;               // j times entry span
  localparam int unsigned MOD_STEPS = J_W - FRAC_BITS;            // integer bits of j
  localparam int unsigned DIV_STEPS = PAL_AW + FRAC_BITS;         // quotient bits

  typedef enum logic [1:0] {
    CFG_MAX_ITER  = 2'd0,
    CFG_CYCLE_LEN = 2'd1,
    CFG_PAL_COUNT = 2'd2,
    CFG_SMOOTH    = 2'd3
  } cfg_idx_e;

  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  // Per-transaction control that travels down the pipeline.
  typedef struct packed {
    logic              vld;
    logic              wr;
    logic [PAL_AW-1:0] idx;
    logic [31:0]       color;
  } ctl_t;

  // Position of the leading one of a word.
  function automatic logic [4:0] msb32(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// ----- sv/fpcm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module fpcm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fractal_palette_color_mapper.sv -----
// ----------------------------------------------------------------------------
// Fractal palette color mapper
// Turns an escape iteration count, optionally smoothed by the escape
// magnitude, into an RGBA color blended between two palette entries.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle, palette writes and pixels alike,
// and returns one color per pixel. Its path includes the two digit-recurrence
// pipelines: 17 stages for the cycle modulo and 20 stages for the position
// divide. Palette writes take effect in order with the pixels around them.
// A two-entry output buffer lets the input keep flowing while one result
// waits; the input stalls only when both entries are full.
module fractal_palette_color_mapper
  import fpcm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [3:0]  palette_index_i,
  input  logic [31:0] palette_color_i,
  input  logic [15:0] iteration_i,
  input  logic [31:0] escape_mag2_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_color_o
);

  // Configuration registers.
  logic [15:0] max_iter_q, cycle_len_q;
  logic [4:0]  pal_count_q;
  logic        smooth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q  <= 16'd256;
      cycle_len_q <= 16'd0;
      pal_count_q <= 5'd2;
      smooth_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_ITER:  max_iter_q  <= cfg_wdata_i;
        CFG_CYCLE_LEN: cycle_len_q <= cfg_wdata_i;
        CFG_PAL_COUNT: pal_count_q <= cfg_wdata_i[4:0];
        CFG_SMOOTH:    smooth_q    <= cfg_wdata_i[0];
      endcase
    end
  end

  // Values derived from configuration; the user must change them only while idle, not enforced.
  logic              cycling;
  logic [15:0]       period, divisor;
  logic [4:0]        pal_cnt;
  logic [PAL_AW-1:0] pal_last;
  logic [4:0]        pal_cnt_m1;

  always_comb begin
    cycling = cycle_len_q >= 16'd2;
    period  = cycle_len_q - 16'd1;
    if (cycling) divisor = period;
    else if (max_iter_q == 16'd0) divisor = 16'd1;
    else divisor = max_iter_q;
    if (pal_count_q < 5'd2) pal_cnt = 5'd2;
    else if (pal_count_q > 5'(PAL_DEPTH)) pal_cnt = 5'(PAL_DEPTH);
    else pal_cnt = pal_count_q;
    pal_cnt_m1 = pal_cnt - 5'd1;
    pal_last   = pal_cnt_m1[PAL_AW-1:0];
  end

  // Output buffer occupancy decides whether the pipeline moves.
  logic [1:0] ocnt_q;
  logic       en;

  assign en         = ocnt_q != 2'd2;
  assign in_stall_o = ~en;

  // Stage 1: capture the transaction.
  ctl_t        s1_ctl_q;
  logic [15:0] s1_iter_q;
  logic [31:0] s1_mag2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else if (en) begin
      s1_ctl_q.vld   <= in_valid_i;
      s1_ctl_q.wr    <= req_type_i == REQ_PALETTE;
      s1_ctl_q.idx   <= palette_index_i;
      s1_ctl_q.color <= palette_color_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_iter_q <= iteration_i;
      s1_mag2_q <= escape_mag2_i;
    end
  end

  // Stage 2: first Mitchell logarithm of the magnitude.
  logic [4:0]  p1, sh1;
  logic [31:0] rem1;
  logic [15:0] fr1;
  logic [19:0] l1_d;
  logic        sm_d;

  always_comb begin
    sm_d = smooth_q & (s1_mag2_q > (32'd1 << MAG_FRAC));
    p1   = msb32(s1_mag2_q);
    sh1  = p1 - 5'(MAG_FRAC);
    rem1 = s1_mag2_q ^ (32'd1 << p1);
    fr1  = 16'(rem1 >> sh1);
    l1_d = {sh1[3:0], fr1};
    if (l1_d == 20'd0) l1_d = 20'd1;
  end

  ctl_t        s2_ctl_q;
  logic [15:0] s2_iter_q;
  logic        s2_sm_q;
  logic [19:0] s2_l1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_ctl_q <= '0;
    else if (en) s2_ctl_q <= s1_ctl_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_iter_q <= s1_iter_q;
      s2_sm_q   <= sm_d;
      s2_l1_q   <= l1_d;
    end
  end

  // Stage 3: second logarithm, a signed value with FRAC_BITS fraction bits.
  logic [4:0]         p2;
  logic [19:0]        rem2;
  logic [15:0]        fr2;
  logic [5:0]         ps2;
  logic signed [21:0] l2_d;

  always_comb begin
    p2   = msb32({12'd0, s2_l1_q});
    rem2 = s2_l1_q ^ (20'd1 << p2);
    if (p2 >= 5'(FRAC_BITS)) fr2 = 16'(rem2 >> (p2 - 5'(FRAC_BITS)));
    else fr2 = 16'(rem2 << (5'(FRAC_BITS) - p2));
    ps2  = {1'b0, p2} - 6'(FRAC_BITS);
    l2_d = $signed({ps2, fr2});
  end

  ctl_t               s3_ctl_q;
  logic [15:0]        s3_iter_q;
  logic               s3_sm_q;
  logic signed [21:0] s3_l2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_ctl_q <= '0;
    else if (en) s3_ctl_q <= s2_ctl_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_iter_q <= s2_iter_q;
      s3_sm_q   <= s2_sm_q;
      s3_l2_q   <= l2_d;
    end
  end

  // Stage 4: position j, clamped at zero.
  logic [16:0]        ip2;
  logic signed [34:0] jt;
  logic [J_W-1:0]     j_d;

  always_comb begin
    ip2 = 17'(s3_iter_q) + 17'd2;
    jt  = $signed({2'b00, ip2, 16'h0000}) - 35'(s3_l2_q);
    if (!s3_sm_q) j_d = {1'b0, s3_iter_q, 16'h0000};
    else if (jt < 0) j_d = '0;
    else j_d = jt[J_W-1:0];
  end

  ctl_t           s4_ctl_q;
  logic [J_W-1:0] s4_j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_ctl_q <= '0;
    else if (en) s4_ctl_q <= s3_ctl_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) s4_j_q <= j_d;
  end

  // Integer part of j modulo the cycle period, one bit per stage.
  ctl_t           mod_ctl_q [MOD_STEPS];
  logic [15:0]    mod_r_q   [MOD_STEPS];
  logic [J_W-1:0] mod_j_q   [MOD_STEPS];

  for (genvar g = 0; g < MOD_STEPS; g++) begin : g_mod
    ctl_t           ctl_in;
    logic [15:0]    r_in, r_d;
    logic [J_W-1:0] j_in;
    logic [16:0]    t;

    if (g == 0) begin : g_first
      assign ctl_in = s4_ctl_q;
      assign r_in   = '0;
      assign j_in   = s4_j_q;
    end else begin : g_next
      assign ctl_in = mod_ctl_q[g-1];
      assign r_in   = mod_r_q[g-1];
      assign j_in   = mod_j_q[g-1];
    end

    assign t   = {r_in, j_in[J_W-1-g]};
    assign r_d = (t >= {1'b0, period}) ? 16'(t - {1'b0, period}) : t[15:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) mod_ctl_q[g] <= '0;
      else if (en) mod_ctl_q[g] <= ctl_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        mod_r_q[g] <= r_d;
        mod_j_q[g] <= j_in;
      end
    end
  end

  // Stage 5: scale the position by the palette span.
  logic [J_W-1:0]   jm;
  logic [NUM_W-1:0] num_d;

  always_comb begin
    if (cycling) jm = {1'b0, mod_r_q[MOD_STEPS-1], mod_j_q[MOD_STEPS-1][FRAC_BITS-1:0]};
    else jm = mod_j_q[MOD_STEPS-1];
    num_d = NUM_W'(jm) * NUM_W'(pal_last);
  end

  ctl_t             s5_ctl_q;
  logic [NUM_W-1:0] s5_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_ctl_q <= '0;
    else if (en) s5_ctl_q <= mod_ctl_q[MOD_STEPS-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) s5_num_q <= num_d;
  end

  // Stage 6: a position at or past the last entry saturates.
  logic [19:0] span_div;
  logic        sat_d;

  assign span_div = 20'(divisor) * 20'(pal_last);
  assign sat_d    = s5_num_q >= {1'b0, span_div, 16'h0000};

  ctl_t             s6_ctl_q;
  logic [NUM_W-1:0] s6_num_q;
  logic             s6_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_ctl_q <= '0;
    else if (en) s6_ctl_q <= s5_ctl_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_num_q <= s5_num_q;
      s6_sat_q <= sat_d;
    end
  end

  // Restoring divide; without saturation the quotient fits DIV_STEPS bits.
  ctl_t                 dv_ctl_q [DIV_STEPS];
  logic [15:0]          dv_r_q   [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_nb_q  [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_qt_q  [DIV_STEPS];
  logic                 dv_sat_q [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    ctl_t                 ctl_in;
    logic [15:0]          r_in, r_d;
    logic [DIV_STEPS-1:0] nb_in, qt_in, qt_d;
    logic                 sat_in, ge;
    logic [16:0]          t;

    if (g == 0) begin : g_first
      assign ctl_in = s6_ctl_q;
      assign r_in   = s6_num_q[DIV_STEPS+15:DIV_STEPS];
      assign nb_in  = s6_num_q[DIV_STEPS-1:0];
      assign qt_in  = '0;
      assign sat_in = s6_sat_q;
    end else begin : g_next
      assign ctl_in = dv_ctl_q[g-1];
      assign r_in   = dv_r_q[g-1];
      assign nb_in  = dv_nb_q[g-1];
      assign qt_in  = dv_qt_q[g-1];
      assign sat_in = dv_sat_q[g-1];
    end

    always_comb begin
      t   = {r_in, nb_in[DIV_STEPS-1-g]};
      ge  = t >= {1'b0, divisor};
      r_d = ge ? 16'(t - {1'b0, divisor}) : t[15:0];
      qt_d = qt_in;
      qt_d[DIV_STEPS-1-g] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_ctl_q[g] <= '0;
      else if (en) dv_ctl_q[g] <= ctl_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_r_q[g]   <= r_d;
        dv_nb_q[g]  <= nb_in;
        dv_qt_q[g]  <= qt_d;
        dv_sat_q[g] <= sat_in;
      end
    end
  end

  // Palette access: writes and reads happen here, in transaction order.
  ctl_t                 lst_ctl;
  logic                 lst_sat;
  logic [PAL_AW-1:0]    k_idx;
  logic [FRAC_BITS-1:0] f_frac;
  logic [PAL_AW-1:0]    raddr_a, raddr_b;
  logic                 pal_we;
  logic [31:0]          rd_a, rd_b;

  assign lst_ctl = dv_ctl_q[DIV_STEPS-1];
  assign lst_sat = dv_sat_q[DIV_STEPS-1];
  assign k_idx   = dv_qt_q[DIV_STEPS-1][DIV_STEPS-1:FRAC_BITS];
  assign f_frac  = dv_qt_q[DIV_STEPS-1][FRAC_BITS-1:0];
  assign raddr_a = lst_sat ? pal_last : k_idx;
  assign raddr_b = k_idx + PAL_AW'(1);
  assign pal_we  = en & lst_ctl.vld & lst_ctl.wr;

  fpcm_ram #(
    .WIDTH (32),
    .DEPTH (16)
  ) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (lst_ctl.idx),
    .wdata_i (lst_ctl.color),
    .re_i    (en),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  fpcm_ram #(
    .WIDTH (32),
    .DEPTH (16)
  ) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (lst_ctl.idx),
    .wdata_i (lst_ctl.color),
    .re_i    (en),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  ctl_t                 s7_ctl_q;
  logic                 s7_sat_q;
  logic [FRAC_BITS-1:0] s7_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_ctl_q <= '0;
    else if (en) s7_ctl_q <= lst_ctl;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_sat_q <= lst_sat;
      s7_f_q   <= f_frac;
    end
  end

  // Blend the two neighboring entries channel by channel.
  logic [31:0] res;
  logic [16:0] w_lo, w_hi;

  always_comb begin
    logic [24:0] pa, pb;
    logic [25:0] sum;
    w_hi = {1'b0, s7_f_q};
    w_lo = 17'h10000 - w_hi;
    res  = {8'hFF, 24'h0};
    for (int ch = 0; ch < 3; ch++) begin
      pa  = 25'(rd_a[8*ch +: 8]) * 25'(w_lo);
      pb  = 25'(rd_b[8*ch +: 8]) * 25'(w_hi);
      sum = 26'(pa) + 26'(pb);
      res[8*ch +: 8] = sum[23:16];
    end
    if (s7_sat_q || rd_a == rd_b) res = rd_a;
  end

  // Two-entry output buffer.
  logic        push, pop;
  logic [31:0] obuf0_q, obuf1_q;

  assign push = en & s7_ctl_q.vld & ~s7_ctl_q.wr;
  assign pop  = (ocnt_q != 2'd0) & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   ocnt_q <= ocnt_q + 2'd1;
        2'b01:   ocnt_q <= ocnt_q - 2'd1;
        default: ocnt_q <= ocnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && pop) begin
      if (ocnt_q == 2'd1) begin
        obuf0_q <= res;
      end else begin
        obuf0_q <= obuf1_q;
        obuf1_q <= res;
      end
    end else if (pop) begin
      obuf0_q <= obuf1_q;
    end else if (push) begin
      if (ocnt_q == 2'd0) obuf0_q <= res;
      else obuf1_q <= res;
    end
  end

  assign out_valid_o   = ocnt_q != 2'd0;
  assign pixel_color_o = obuf0_q;

  // The buffer never holds more than two results.
  a_ocnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q != 2'd3)
    else $error("output buffer occupancy out of range");

  // A full buffer freezes the pipeline, so nothing arrives to overflow it.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q == 2'd2) |-> !push)
    else $error("result pushed into a full output buffer");

  // Without saturation the divided position lies below the last entry.
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lst_ctl.vld && !lst_ctl.wr && !lst_sat) |-> (k_idx < pal_last))
    else $error("palette index past the last entry");

  // The first logarithm is never zero where the second one takes it.
  a_l1_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_ctl_q.vld && s2_sm_q) |-> (s2_l1_q != 20'd0))
    else $error("zero logarithm fed to the second logarithm");

endmodule
